FILE: design/sip64_pkg.sv
// ----------------------------------------------------------------------------
// sip64_pkg
// Shared constants, types and round functions for the 64-bit SipHash block.
// ----------------------------------------------------------------------------
`default_nettype none

package sip64_pkg;

  // round counts
  localparam int unsigned COMPRESS_ROUNDS = 2;
  localparam int unsigned FINAL_ROUNDS    = 4;
  // finalization rounds split over two pipeline stages
  localparam int unsigned FIN_ROUNDS_A    = FINAL_ROUNDS - FINAL_ROUNDS / 2;
  localparam int unsigned FIN_ROUNDS_B    = FINAL_ROUNDS / 2;
  localparam int unsigned MAX_ROUNDS      = 8;

  // initialization vectors
  localparam logic [63:0] IV0 = 64'h736f6d65_70736575;
  localparam logic [63:0] IV1 = 64'h646f7261_6e646f6d;
  localparam logic [63:0] IV2 = 64'h6c796765_6e657261;
  localparam logic [63:0] IV3 = 64'h74656462_79746573;
  localparam logic [63:0] FIN_XOR = 64'h0000_0000_0000_00ff;

  typedef struct packed {
    logic [63:0] v0;
    logic [63:0] v1;
    logic [63:0] v2;
    logic [63:0] v3;
  } sip_state_t;

  // request from the absorb loop to the finalization pipeline
  typedef struct packed {
    logic        valid;
    sip_state_t  state;
    logic [63:0] block;
  } fin_req_t;

  // state derived from the key seed
  function automatic sip_state_t sip_init(input logic [63:0] seed);
    sip_state_t s;
    s.v0 = IV0 ^ seed;
    s.v1 = IV1 ^ ~seed;
    s.v2 = IV2 ^ seed;
    s.v3 = IV3 ^ ~seed;
    return s;
  endfunction

  // one sip round
  function automatic sip_state_t sip_round(input sip_state_t si);
    sip_state_t s;
    s = si;
    s.v0 = s.v0 + s.v1;
    s.v1 = {s.v1[50:0], s.v1[63:51]};
    s.v1 = s.v1 ^ s.v0;
    s.v0 = {s.v0[31:0], s.v0[63:32]};
    s.v2 = s.v2 + s.v3;
    s.v3 = {s.v3[47:0], s.v3[63:48]};
    s.v3 = s.v3 ^ s.v2;
    s.v2 = s.v2 + s.v1;
    s.v1 = {s.v1[46:0], s.v1[63:47]};
    s.v1 = s.v1 ^ s.v2;
    s.v2 = {s.v2[31:0], s.v2[63:32]};
    s.v0 = s.v0 + s.v3;
    s.v3 = {s.v3[42:0], s.v3[63:43]};
    s.v3 = s.v3 ^ s.v0;
    return s;
  endfunction

  // a fixed number of rounds, at most MAX_ROUNDS
  function automatic sip_state_t sip_rounds(input sip_state_t si, input int unsigned n);
    sip_state_t s;
    s = si;
    for (int unsigned i = 0; i < MAX_ROUNDS; i++) begin
      if (i < n) begin
        s = sip_round(s);
      end
    end
    return s;
  endfunction

  // absorb one 64-bit block
  function automatic sip_state_t sip_absorb(input sip_state_t si, input logic [63:0] m);
    sip_state_t s;
    s = si;
    s.v3 = s.v3 ^ m;
    s = sip_rounds(s, COMPRESS_ROUNDS);
    s.v0 = s.v0 ^ m;
    return s;
  endfunction

endpackage

`default_nettype wire

FILE: design/sip64_if.sv
// ----------------------------------------------------------------------------
// sip64 channel interfaces
// Valid/ready channels for message words and hash results.
// ----------------------------------------------------------------------------
`default_nettype none

// message word channel
interface sip64_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] message_word;
  logic [3:0]  valid_bytes;
  logic        is_last;

  modport source (output valid, output message_word, output valid_bytes,
                  output is_last, input ready);
  modport sink   (input valid, input message_word, input valid_bytes,
                  input is_last, output ready);
endinterface

// hash result channel
interface sip64_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] hash_value;

  modport source (output valid, output hash_value, input ready);
  modport sink   (input valid, input hash_value, output ready);
endinterface

`default_nettype wire

FILE: design/siphash_64bit_keyed_hash.sv
// ----------------------------------------------------------------------------
// siphash_64bit_keyed_hash
// Streaming SipHash-2-4 over little-endian 64-bit message words with a key
// derived from a 64-bit seed (k0 = seed, k1 = ~seed).
// ----------------------------------------------------------------------------
// One message word is accepted every cycle unless a last word waits on
// finalization: the running state absorbs a full word (two rounds) in the
// cycle after it is registered, and that loop through the state register sets
// the rate. The last word of a message carries 0 to 8 valid bytes; its hash
// reaches the output through a three-stage finalization pipeline, while the
// next message already streams in. Writing the key seed restarts the state
// and the length; write it only while no message is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module siphash_64bit_keyed_hash (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          cfg_we,
  input  wire [63:0]   cfg_wdata,
  sip64_in_if.sink     in_chan,
  sip64_out_if.source  out_chan
);
  import sip64_pkg::*;

  fin_req_t fin_req;
  logic     fin_ready;

  // running state and input register
  sip64_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_chan),
    .fin_req   (fin_req),
    .fin_ready (fin_ready)
  );

  // finalization pipeline and output register
  sip64_final u_final (
    .clk       (clk),
    .rst_n     (rst_n),
    .fin_req   (fin_req),
    .fin_ready (fin_ready),
    .out_chan  (out_chan)
  );

endmodule

`default_nettype wire

FILE: design/sip64_core.sv
// ----------------------------------------------------------------------------
// sip64_core
// Input register, key and running state; absorbs one full word per cycle unless a
// last word waits on finalization, and hands the state and final block of a finished message to finalization.
// ----------------------------------------------------------------------------
`default_nettype none

module sip64_core (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 cfg_we,
  input  wire [63:0]          cfg_wdata,
  sip64_in_if.sink            in_chan,
  output sip64_pkg::fin_req_t fin_req,
  input  wire                 fin_ready
);
  import sip64_pkg::*;

  logic        s0_v_r;
  logic [63:0] s0_word_r;
  logic [3:0]  s0_nbytes_r;
  logic        s0_last_r;

  logic [63:0] key_r;
  sip_state_t  v_r;
  logic [7:0]  len_r;

  logic        s0_fire;
  logic        full_last;
  sip_state_t  absorbed;
  logic [63:0] tail;
  logic [7:0]  len_fin;

  // input register advances unless a last word waits on finalization
  assign s0_fire       = s0_v_r && (!s0_last_r || fin_ready);
  assign in_chan.ready = !s0_v_r || s0_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (in_chan.ready) begin
      s0_v_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      s0_word_r   <= in_chan.message_word;
      s0_nbytes_r <= in_chan.valid_bytes;
      s0_last_r   <= in_chan.is_last;
    end
  end

  // absorb the registered word
  assign absorbed  = sip_absorb(v_r, s0_word_r);
  assign full_last = s0_nbytes_r[3];

  // tail bytes of a short last word
  always_comb begin
    tail = '0;
    for (int unsigned b = 0; b < 8; b++) begin
      if (4'(b) < s0_nbytes_r) begin
        tail[8*b +: 8] = s0_word_r[8*b +: 8];
      end
    end
  end

  assign len_fin = full_last ? len_r + 8'd8 : len_r + {4'd0, s0_nbytes_r};

  // request to finalization
  always_comb begin
    fin_req.valid = s0_v_r && s0_last_r;
    fin_req.state = full_last ? absorbed : v_r;
    fin_req.block = {len_fin, (full_last ? 56'd0 : tail[55:0])};
  end

  // key and running state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
      v_r   <= sip_init(64'd0);
      len_r <= '0;
    end else if (cfg_we) begin
      key_r <= cfg_wdata;
      v_r   <= sip_init(cfg_wdata);
      len_r <= '0;
    end else if (s0_fire) begin
      if (s0_last_r) begin
        v_r   <= sip_init(key_r);
        len_r <= '0;
      end else begin
        v_r   <= absorbed;
        len_r <= len_r + 8'd8;
      end
    end
  end

`ifndef NO_ASSERTIONS
  // finishing a message restarts the state from the key
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    s0_fire && s0_last_r && !cfg_we |=> v_r == sip_init(key_r) && len_r == 8'd0)
    else $error("state not re-initialized after last word");

  // a full word adds eight bytes to the length
  a_len_step: assert property (@(posedge clk) disable iff (!rst_n)
    s0_fire && !s0_last_r && !cfg_we |=> len_r == $past(len_r) + 8'd8)
    else $error("length not advanced by a full word");

  // a stalled last word keeps its request to finalization
  a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
    fin_req.valid && !fin_ready && !cfg_we |=> fin_req.valid && $stable(fin_req.block))
    else $error("finalization request dropped or changed while stalled");
`endif

endmodule

`default_nettype wire

FILE: design/sip64_final.sv
// ----------------------------------------------------------------------------
// sip64_final
// Three-stage finalization pipeline: absorb the final block, then the
// finalization rounds in two halves, ending in the hash output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sip64_final (
  input  wire                 clk,
  input  wire                 rst_n,
  input  sip64_pkg::fin_req_t fin_req,
  output logic                fin_ready,
  sip64_out_if.source         out_chan
);
  import sip64_pkg::*;

  logic        f1_v_r, f2_v_r, f3_v_r;
  sip_state_t  f1_st_r, f2_st_r;
  logic [63:0] hash_r;

  logic        ld1, ld2, ld3;
  logic        en1, en2, en3;
  sip_state_t  f1_nxt, f2_in, f2_nxt, f3_st;

  // stage enables, each stage loads when empty or draining
  assign en3       = !f3_v_r || out_chan.ready;
  assign ld3       = f2_v_r && en3;
  assign en2       = !f2_v_r || ld3;
  assign ld2       = f1_v_r && en2;
  assign en1       = !f1_v_r || ld2;
  assign ld1       = fin_req.valid && en1;
  assign fin_ready = en1;

  // stage 1: absorb final block
  assign f1_nxt = sip_absorb(fin_req.state, fin_req.block);

  // stage 2: first half of finalization rounds
  always_comb begin
    f2_in    = f1_st_r;
    f2_in.v2 = f1_st_r.v2 ^ FIN_XOR;
  end
  assign f2_nxt = sip_rounds(f2_in, FIN_ROUNDS_A);

  // stage 3: remaining rounds and fold
  assign f3_st = sip_rounds(f2_st_r, FIN_ROUNDS_B);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
      f3_v_r <= 1'b0;
    end else begin
      if (en1) f1_v_r <= fin_req.valid;
      if (en2) f2_v_r <= f1_v_r;
      if (en3) f3_v_r <= f2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) f1_st_r <= f1_nxt;
    if (ld2) f2_st_r <= f2_nxt;
    if (ld3) hash_r  <= f3_st.v0 ^ f3_st.v1 ^ f3_st.v2 ^ f3_st.v3;
  end

  assign out_chan.valid      = f3_v_r;
  assign out_chan.hash_value = hash_r;

`ifndef NO_ASSERTIONS
  // an accepted request reaches stage 1
  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    ld1 |=> f1_v_r)
    else $error("accepted request lost at stage 1");

  // stage 2 holds its state while the output is blocked
  a_hold2: assert property (@(posedge clk) disable iff (!rst_n)
    f2_v_r && !ld3 |=> f2_v_r && $stable(f2_st_r))
    else $error("stage 2 changed while stalled");

  // moving into stage 3 always yields a valid result
  a_take3: assert property (@(posedge clk) disable iff (!rst_n)
    ld3 |=> f3_v_r)
    else $error("result lost at output register");
`endif

endmodule

`default_nettype wire
